[src/rts_pkg.sv]
package rts_pkg;

    // Width of the shared tick counter
    localparam int COUNT_WIDTH = 16;
    // Width of the interval registers and of the reported reaction time
    localparam int INTERVAL_WIDTH = 16;
    localparam int REACTION_WIDTH = 16;
    // Compare width: wide enough for both the counter and an interval
    localparam int CMP_WIDTH = (COUNT_WIDTH > INTERVAL_WIDTH) ? COUNT_WIDTH : INTERVAL_WIDTH;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = INTERVAL_WIDTH;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_INTERVAL  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_INTERVAL = 1'b1;

    localparam logic [INTERVAL_WIDTH-1:0] LONG_INTERVAL_RESET  = 16'd1000;
    localparam logic [INTERVAL_WIDTH-1:0] SHORT_INTERVAL_RESET = 16'd100;

    // Stream widths: input is button_level, output is
    // red_light, green_light, reaction_ms, captured, padded to bytes
    localparam int S_TDATA_WIDTH = 8;
    localparam int M_FIELD_BITS  = 2 + REACTION_WIDTH + 1;
    localparam int M_TDATA_WIDTH = ((M_FIELD_BITS + 7) / 8) * 8;

    // Cue sequence
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_WAIT1  = 7'b0000010,
        PH_GREEN1 = 7'b0000100,
        PH_WAIT2  = 7'b0001000,
        PH_GREEN2 = 7'b0010000,
        PH_WAIT3  = 7'b0100000,
        PH_RED    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [INTERVAL_WIDTH-1:0] long_interval;
        logic [INTERVAL_WIDTH-1:0] short_interval;
    } cfg_t;

    typedef struct packed {
        logic                      captured;
        logic [REACTION_WIDTH-1:0] reaction_ms;
        logic                      green_light;
        logic                      red_light;
    } result_t;

endpackage

[src/rts_cfg.sv]
module rts_cfg (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rts_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rts_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    output rts_pkg::cfg_t                         cfg
);
    import rts_pkg::*;

    logic [INTERVAL_WIDTH-1:0] long_reg;
    logic [INTERVAL_WIDTH-1:0] short_reg;

    // Interval registers, written one at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_reg  <= LONG_INTERVAL_RESET;
            short_reg <= SHORT_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LONG_INTERVAL:  long_reg  <= cfg_wdata;
                REG_SHORT_INTERVAL: short_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.long_interval  = long_reg;
    assign cfg.short_interval = short_reg;

endmodule

[src/rts_core.sv]
module rts_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             button_level,
    input  rts_pkg::cfg_t    cfg,
    output rts_pkg::result_t result
);
    import rts_pkg::*;

    logic                      prev_button_reg, prev_button_next;
    phase_t                    phase_reg, phase_next;
    logic                      timing_reg, timing_next;
    logic                      stop_reg, stop_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [REACTION_WIDTH-1:0] reaction_reg, reaction_next;
    logic                      red_reg, red_next;
    logic                      green_reg, green_next;
    logic                      captured;

    logic                      fall;
    logic [COUNT_WIDTH-1:0]    count_inc;
    logic [CMP_WIDTH-1:0]      count_inc_ext;
    logic [CMP_WIDTH-1:0]      count_cue_ext;
    logic                      hit_long;
    logic                      hit_short;

    assign fall          = !button_level && prev_button_reg;
    assign count_inc     = count_reg + COUNT_WIDTH'(1);
    assign count_inc_ext = CMP_WIDTH'(count_inc);
    assign hit_long      = count_inc_ext == CMP_WIDTH'(cfg.long_interval);
    assign hit_short     = count_inc_ext == CMP_WIDTH'(cfg.short_interval);

    // One tick: edge detect, cue phase, then timing
    always_comb begin
        prev_button_next = button_level;
        phase_next       = phase_reg;
        timing_next      = timing_reg;
        stop_next        = stop_reg;
        count_next       = count_reg;
        reaction_next    = reaction_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        captured         = 1'b0;
        count_cue_ext    = '0;

        // press: start a cue when idle, request a stop while timing
        if (fall) begin
            if (phase_reg == PH_IDLE && !timing_reg) begin
                phase_next = PH_WAIT1;
                red_next   = 1'b0;
            end
            if (timing_reg) begin
                stop_next = 1'b1;
            end
        end

        // cue sequence from the phase after the press; the starting tick counts
        case (phase_next)
            PH_WAIT1, PH_WAIT2: begin
                count_next = hit_long ? '0 : count_inc;
                if (hit_long) begin
                    phase_next = (phase_next == PH_WAIT1) ? PH_GREEN1 : PH_GREEN2;
                    green_next = 1'b1;
                end
            end
            PH_GREEN1, PH_GREEN2: begin
                count_next = hit_short ? '0 : count_inc;
                if (hit_short) begin
                    phase_next = (phase_next == PH_GREEN1) ? PH_WAIT2 : PH_WAIT3;
                    green_next = 1'b0;
                end
            end
            PH_WAIT3: begin
                count_next = hit_long ? '0 : count_inc;
                if (hit_long) begin
                    phase_next = PH_RED;
                    red_next   = 1'b1;
                end
            end
            PH_RED: begin
                count_next = hit_short ? '0 : count_inc;
                if (hit_short) begin
                    phase_next  = PH_IDLE;
                    red_next    = 1'b0;
                    timing_next = 1'b1;
                    stop_next   = 1'b0;
                end
            end
            default: ;
        endcase

        // timing: count ticks until a stop, then capture
        if (timing_next) begin
            if (stop_next) begin
                count_cue_ext = CMP_WIDTH'(count_next);
                reaction_next = count_cue_ext[REACTION_WIDTH-1:0];
                count_next    = '0;
                timing_next   = 1'b0;
                red_next      = 1'b1;
                captured      = 1'b1;
            end else begin
                count_next = count_next + COUNT_WIDTH'(1);
            end
        end
    end

    // State advances once per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_button_reg <= 1'b1;
            phase_reg       <= PH_IDLE;
            timing_reg      <= 1'b0;
            stop_reg        <= 1'b1;
            count_reg       <= '0;
            reaction_reg    <= '0;
            red_reg         <= 1'b0;
            green_reg       <= 1'b0;
        end else if (step) begin
            prev_button_reg <= prev_button_next;
            phase_reg       <= phase_next;
            timing_reg      <= timing_next;
            stop_reg        <= stop_next;
            count_reg       <= count_next;
            reaction_reg    <= reaction_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
        end
    end

    assign result.red_light   = red_next;
    assign result.green_light = green_next;
    assign result.reaction_ms = reaction_next;
    assign result.captured    = captured;

endmodule

[src/reaction_timer_sequencer.sv]
// Reaction timer sequencer.
// Input stream (s_): one transfer per millisecond tick, tdata[0] is the
// button level (0 pressed). A press while idle runs the light cue
// (long wait, green, short, off, again, long wait, red, short, off), then
// timing starts; the next press captures the tick count as reaction time.
// Output stream (m_): exactly one transfer per input transfer, carrying
// the lamp drives, the last captured reaction time and a capture flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the long (index 0)
// and short (index 1) intervals; write only while no tick is in flight.
// Path: the input register, then the state update into the output register.
// Throughput: one tick per cycle while m_tready is high; the state update is
// combinational compare and increment logic between the input register and
// the output register.
// Reset: synchronous, active low; clears the pipeline, lamps off, intervals
// back to 1000 and 100 ticks.
// When m_tready is low the result holds in the output register, the input
// register fills and s_tready then drops; nothing is lost.
module reaction_timer_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [0] button_level, [7:1] zero
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rts_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
    // m_tdata: [0] red_light, [1] green_light, [17:2] reaction_ms,
    // [18] captured, [23:19] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rts_pkg::M_TDATA_WIDTH-1:0]    m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [rts_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rts_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
    import rts_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic in_valid_reg, in_valid_next;
    logic in_level_reg;
    logic out_valid_reg, out_valid_next;
    logic [M_TDATA_WIDTH-1:0] out_data_reg;
    logic advance;

    rts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rts_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .button_level (in_level_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Move the held tick forward when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (advance) begin
            out_data_reg <= M_TDATA_WIDTH'(result);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/rts_checker.sv]
module rts_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [rts_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rts_pkg::M_TDATA_WIDTH-1:0]    m_tdata
);
    import rts_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled input transfer stays offered with the same data
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while stalled");

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output dropped while stalled");

    // Green and red are never driven together
    a_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both lamps on");

    // A capture always lights red
    a_capture_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_FIELD_BITS-1] |-> m_tdata[0])
        else $error("capture without red lamp");

endmodule

bind reaction_timer_sequencer rts_checker u_rts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import rts_pkg::*;

    // Input transfer to output transfer passes the input and the output register
    localparam int PIPE_LAT = 2;
    // The watchdog limit lies far above the length of a correct run.
    localparam int LIMIT_CYCLES = 100_000;
    localparam int IDLE_PCT = 9;

    typedef enum logic [1:0] {
        ROW_KNOWN,   // expected lamps typed in below
        ROW_TICK,    // expected lamps from the predictor
        ROW_CFG,     // write both intervals with nothing in flight
        ROW_RUN      // random ticks until the cue has run out
    } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic                      lvl;
        result_t                   want;
        logic [INTERVAL_WIDTH-1:0] lg;
        logic [INTERVAL_WIDTH-1:0] sh;
    } row_t;

    localparam result_t DARK = '0;

    row_t dir_rows [23] = '{
        '{ROW_KNOWN, 1'b1, DARK, 16'd0, 16'd0},  // after reset, all dark
        '{ROW_KNOWN, 1'b0, DARK, 16'd0, 16'd0},  // press starts the cue
        '{ROW_KNOWN, 1'b0, DARK, 16'd0, 16'd0},  // held low, no new edge
        '{ROW_KNOWN, 1'b1, DARK, 16'd0, 16'd0},
        '{ROW_KNOWN, 1'b0, DARK, 16'd0, 16'd0},  // press during the cue is ignored
        '{ROW_CFG,   1'b1, DARK, 16'd6, 16'd3},  // shorten the running cue
        '{ROW_RUN,   1'b1, DARK, 16'd0, 16'd0},  // rest of the cue
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},  // press stops the clock
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},  // held low while idle
        '{ROW_CFG,   1'b1, DARK, 16'd1, 16'd1},  // shortest intervals
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},  // cue starts, green at once
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},  // red on
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},  // press on the tick the cue ends
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0},  // capture
        '{ROW_TICK,  1'b1, DARK, 16'd0, 16'd0},
        '{ROW_TICK,  1'b0, DARK, 16'd0, 16'd0}   // next cue starts
    };

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_WIDTH-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    reaction_timer_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state, reset values
    logic [INTERVAL_WIDTH-1:0] long_ivl = LONG_INTERVAL_RESET;
    logic [INTERVAL_WIDTH-1:0] short_ivl = SHORT_INTERVAL_RESET;
    phase_t                    cue = PH_IDLE;
    logic                      btn_prev = 1'b1;
    logic                      timing_on = 1'b0;
    logic                      stop_pending = 1'b1;
    logic [COUNT_WIDTH-1:0]    ticks = '0;
    logic [REACTION_WIDTH-1:0] reaction = '0;
    logic                      red_on = 1'b0;
    logic                      green_on = 1'b0;

    result_t lamps_due [$];
    result_t lamp_want;
    result_t lamp_got;
    int      mismatches = 0;
    int      cycle_cnt = 0;
    logic    steady = 1'b0;    // no idling on either side
    logic    last_lvl = 1'b1;  // level of the last accepted tick

    // Shared counter: count up, clear and report on reaching the limit
    function automatic logic count_hits(input logic [INTERVAL_WIDTH-1:0] limit);
        ticks = ticks + 1'b1;
        if (CMP_WIDTH'(ticks) == CMP_WIDTH'(limit)) begin
            ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One millisecond tick: edge detect, cue update, then timing
    function automatic result_t step_sequencer(input logic lvl);
        result_t r;
        r = '0;
        if (!lvl && btn_prev) begin
            if (cue == PH_IDLE && !timing_on) begin
                cue = PH_WAIT1;
                red_on = 1'b0;
            end
            if (timing_on) stop_pending = 1'b1;
        end
        btn_prev = lvl;

        case (cue)
            PH_WAIT1, PH_WAIT2: begin
                if (count_hits(long_ivl)) begin
                    cue = (cue == PH_WAIT1) ? PH_GREEN1 : PH_GREEN2;
                    green_on = 1'b1;
                end
            end
            PH_GREEN1, PH_GREEN2: begin
                if (count_hits(short_ivl)) begin
                    cue = (cue == PH_GREEN1) ? PH_WAIT2 : PH_WAIT3;
                    green_on = 1'b0;
                end
            end
            PH_WAIT3: begin
                if (count_hits(long_ivl)) begin
                    cue = PH_RED;
                    red_on = 1'b1;
                end
            end
            PH_RED: begin
                if (count_hits(short_ivl)) begin
                    cue = PH_IDLE;
                    red_on = 1'b0;
                    timing_on = 1'b1;
                    stop_pending = 1'b0;
                end
            end
            default: ;
        endcase

        // Timing counts the tick the cue ends on; a press captures the count
        if (timing_on) begin
            if (stop_pending) begin
                reaction = REACTION_WIDTH'(ticks);
                ticks = '0;
                timing_on = 1'b0;
                red_on = 1'b1;
                r.captured = 1'b1;
            end else begin
                ticks = ticks + 1'b1;
            end
        end

        r.red_light = red_on;
        r.green_light = green_on;
        r.reaction_ms = reaction;
        return r;
    endfunction

    // Drive one tick, wait for the transfer, queue what it should produce
    task automatic send_tick(input logic lvl, input logic known = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_WIDTH'(lvl);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = step_sequencer(lvl);
        lamps_due.push_back(known ? want : predicted);
        last_lvl = lvl;
    endtask

    // Button behavior shaped by where the sequencer is
    task automatic random_tick();
        int press_pct;
        if (!last_lvl) press_pct = 40;
        else if (timing_on) press_pct = 8;
        else if (cue == PH_IDLE) press_pct = 50;
        else press_pct = 15;
        send_tick(($urandom_range(99) < press_pct) ? 1'b0 : 1'b1);
    endtask

    task automatic run_to_timing();
        while (!timing_on) random_tick();
    endtask

    // Run until no cue and no timing, so the counter is clear
    task automatic settle();
        while (cue != PH_IDLE || timing_on) random_tick();
    endtask

    // Stop sending until every queued result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (lamps_due.size() != 0) @(posedge aclk);
        repeat (4 * PIPE_LAT) @(posedge aclk);
    endtask

    task automatic set_intervals(input logic [INTERVAL_WIDTH-1:0] lg,
                                 input logic [INTERVAL_WIDTH-1:0] sh);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LONG_INTERVAL;
        cfg_wdata <= lg;
        @(posedge aclk);
        cfg_index <= REG_SHORT_INTERVAL;
        cfg_wdata <= sh;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        long_ivl = lg;
        short_ivl = sh;
    endtask

    // Result side: random backpressure and field checks
    always @(posedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            if (lamps_due.size() == 0) begin
                $display("%0t: transfer with nothing expected, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                lamp_want = lamps_due.pop_front();
                lamp_got = result_t'(m_tdata[M_FIELD_BITS-1:0]);
                if (lamp_got.red_light !== lamp_want.red_light) begin
                    $display("%0t: red_light expected %0d got %0d", $time,
                             lamp_want.red_light, lamp_got.red_light);
                    mismatches++;
                end
                if (lamp_got.green_light !== lamp_want.green_light) begin
                    $display("%0t: green_light expected %0d got %0d", $time,
                             lamp_want.green_light, lamp_got.green_light);
                    mismatches++;
                end
                if (lamp_got.reaction_ms !== lamp_want.reaction_ms) begin
                    $display("%0t: reaction_ms expected %0d got %0d", $time,
                             lamp_want.reaction_ms, lamp_got.reaction_ms);
                    mismatches++;
                end
                if (lamp_got.captured !== lamp_want.captured) begin
                    $display("%0t: captured expected %0d got %0d", $time,
                             lamp_want.captured, lamp_got.captured);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("reaction_timer_sequencer: mismatch");
            $finish;
        end
    end

    initial begin
        logic [INTERVAL_WIDTH-1:0] lg;
        logic [INTERVAL_WIDTH-1:0] sh;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_KNOWN: send_tick(dir_rows[i].lvl, 1'b1, dir_rows[i].want);
                ROW_TICK:  send_tick(dir_rows[i].lvl);
                ROW_RUN:   run_to_timing();
                ROW_CFG: begin
                    drain();
                    set_intervals(dir_rows[i].lg, dir_rows[i].sh);
                end
                default: ;
            endcase
        end

        // Random button activity over several small interval settings
        for (int p = 0; p < 7; p++) begin
            settle();
            drain();
            case (p)
                0: begin lg = 16'd1; sh = 16'd1; end
                1: begin lg = 16'd2; sh = 16'd1; end
                2: begin lg = 16'd1; sh = 16'd3; end
                default: begin
                    lg = INTERVAL_WIDTH'($urandom_range(8, 1));
                    sh = INTERVAL_WIDTH'($urandom_range(8, 1));
                end
            endcase
            set_intervals(lg, sh);
            steady = (p == 3 || p == 4);
            for (int k = 0; k < 100; k++) begin
                // hold off mid-phase until the pipeline is empty
                if (p == 2 && k == 50) drain();
                random_tick();
            end
            steady = 1'b0;
        end

        drain();
        if (mismatches == 0 && lamps_due.size() == 0) begin
            $display("reaction_timer_sequencer: match");
        end else begin
            $display("reaction_timer_sequencer: mismatch");
        end
        $finish;
    end

endmodule
